@@ rtl/msc_pkg.sv @@
package msc_pkg;

   localparam int NCH          = 8;
   localparam int CH_W         = 3;
   localparam int SUM_W        = 40;
   localparam int FILT_W       = 32;
   localparam int CALIB_FRAMES = 200;
   localparam int COUNT_LIMIT  = 250;
   localparam int CNT_W        = 8;
   localparam int DIV_W        = 41;
   localparam int DIV_CNT_W    = 6;
   localparam int RAM_W        = 2 * SUM_W + FILT_W;

   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_MV_GAIN = 2'd1;
   localparam logic [1:0] REG_FIELD_GAIN = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV1_START,
      ST_DIV1_WAIT,
      ST_DIV2_START,
      ST_DIV2_WAIT,
      ST_CAL_START,
      ST_CAL_WAIT,
      ST_WRITE,
      ST_CLEAR,
      ST_OUT
   } state_type;

endpackage

@@ rtl/msc_ram.sv @@
module msc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ rtl/msc_div.sv @@
module msc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [msc_pkg::DIV_W-1:0] dividend,
   input  logic [msc_pkg::CNT_W-1:0]        divisor,
   output logic                             done,
   output logic signed [msc_pkg::DIV_W-1:0] quotient
);

   logic [msc_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [msc_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [msc_pkg::CNT_W-1:0]     den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic [msc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [msc_pkg::DIV_W-1:0]     magnitude;
   logic [msc_pkg::CNT_W:0]       trial;
   logic [msc_pkg::DIV_W-1:0]     rem_shift;

   always_comb begin
      magnitude = dividend[msc_pkg::DIV_W-1] ? -dividend : dividend;
      rem_shift = {rem_ff[msc_pkg::DIV_W-2:0], quo_ff[msc_pkg::DIV_W-1]};
      trial = rem_shift[msc_pkg::CNT_W:0] - {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = magnitude;
         den_in = divisor;
         neg_in = dividend[msc_pkg::DIV_W-1];
         cnt_in = msc_pkg::DIV_CNT_W'(msc_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[msc_pkg::DIV_W-2:0], 1'b0};
         if (!trial[msc_pkg::CNT_W]) begin
            rem_in = msc_pkg::DIV_W'(trial);
            quo_in[0] = 1'b1;
         end else begin
            rem_in = rem_shift;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == msc_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

@@ rtl/multichannel_sample_conditioner.sv @@
// Channel  | Handshake                    | Contents
// req      | req_valid / req_stall        | eight codes, calibrate_request
// rsp      | rsp_valid / rsp_stall        | eight field values, calibrating
// csr      | APB psel/penable, pready=1   | window, two gains
// Each channel is processed in turn: one read, one serial divider pass (start-up mean) or
// two (leaky filter), plus one more on the frame that ends a calibration, then one write.
// The response becomes valid once the last channel is written and the output stage loads.
// A request is taken while the previous response still waits in the output stage.
// Reset is synchronous; a clearing pass over the eight RAM entries follows it, no request taken.
// Stalling rsp holds the response; a finished request waits until the stage frees.
module multichannel_sample_conditioner (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_code_ch0,
   input  logic signed [15:0] req_code_ch1,
   input  logic signed [15:0] req_code_ch2,
   input  logic signed [15:0] req_code_ch3,
   input  logic signed [15:0] req_code_ch4,
   input  logic signed [15:0] req_code_ch5,
   input  logic signed [15:0] req_code_ch6,
   input  logic signed [15:0] req_code_ch7,
   input  logic               req_calibrate_request,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_field_ch0,
   output logic signed [31:0] rsp_field_ch1,
   output logic signed [31:0] rsp_field_ch2,
   output logic signed [31:0] rsp_field_ch3,
   output logic signed [31:0] rsp_field_ch4,
   output logic signed [31:0] rsp_field_ch5,
   output logic signed [31:0] rsp_field_ch6,
   output logic signed [31:0] rsp_field_ch7,
   output logic               rsp_calibrating,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic signed [63:0] SUM_MAX = 64'sd549755813887;
   localparam logic signed [63:0] SUM_MIN = -64'sd549755813888;
   localparam logic signed [63:0] F_MAX = 64'sd2147483647;
   localparam logic signed [63:0] F_MIN = -64'sd2147483648;

   msc_pkg::state_type state_ff, state_in;

   logic [7:0]  window_ff;
   logic [15:0] mv_gain_ff;
   logic [15:0] field_gain_ff;
   logic [1:0]  reg_sel;

   logic signed [15:0] code_ff [msc_pkg::NCH];
   logic signed [15:0] code_in [msc_pkg::NCH];
   logic [msc_pkg::CH_W-1:0] ch_ff, ch_in;
   logic [msc_pkg::CNT_W-1:0] startup_ff, startup_in;
   logic [msc_pkg::CNT_W-1:0] n_ff, n_in;
   logic [msc_pkg::CNT_W-1:0] w_ff, w_in;
   logic [msc_pkg::CNT_W-1:0] calcnt_ff, calcnt_in;
   logic        calact_ff, calact_in;
   logic        calupd_ff, calupd_in;
   logic        calfin_ff, calfin_in;
   logic        busy_ff, busy_in;

   logic signed [msc_pkg::SUM_W-1:0]  fsum_ff, fsum_in;
   logic signed [msc_pkg::SUM_W-1:0]  csum_ff, csum_in;
   logic signed [msc_pkg::FILT_W-1:0] off_ff, off_in;
   logic signed [msc_pkg::FILT_W-1:0] filt_ff, filt_in;
   logic signed [31:0] mv_ff, mv_in;

   logic signed [31:0] res_ff [msc_pkg::NCH];
   logic signed [31:0] res_in [msc_pkg::NCH];
   logic signed [31:0] out_ff [msc_pkg::NCH];
   logic        out_cal_ff, res_cal_ff, res_cal_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        load_out;

   logic        ram_we;
   logic [msc_pkg::CH_W-1:0] ram_waddr, ram_raddr;
   logic [msc_pkg::RAM_W-1:0] ram_wdata, ram_rdata;

   logic        div_start, div_done;
   logic signed [msc_pkg::DIV_W-1:0] div_num, div_q;
   logic [msc_pkg::CNT_W-1:0] div_den;

   logic signed [63:0] wide_a, wide_b;
   logic signed [50:0] prod;
   logic signed [32:0] diff;
   logic        accept;

   msc_ram #(
      .WIDTH(msc_pkg::RAM_W),
      .DEPTH(msc_pkg::NCH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   msc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .done    (div_done),
      .quotient(div_q)
   );

   assign reg_sel = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_sel)
         msc_pkg::REG_WINDOW:     csr_prdata = {24'd0, window_ff};
         msc_pkg::REG_MV_GAIN:    csr_prdata = {16'd0, mv_gain_ff};
         msc_pkg::REG_FIELD_GAIN: csr_prdata = {16'd0, field_gain_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 8'd5;
         mv_gain_ff <= 16'd9961;
         field_gain_ff <= 16'd10112;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_sel)
            msc_pkg::REG_WINDOW:     window_ff <= csr_pwdata[7:0];
            msc_pkg::REG_MV_GAIN:    mv_gain_ff <= csr_pwdata[15:0];
            msc_pkg::REG_FIELD_GAIN: field_gain_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   assign req_stall = busy_ff || (state_ff != msc_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign load_out = (state_ff == msc_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      startup_in = startup_ff;
      n_in = n_ff;
      w_in = w_ff;
      calcnt_in = calcnt_ff;
      calact_in = calact_ff;
      calupd_in = calupd_ff;
      calfin_in = calfin_ff;
      busy_in = busy_ff;
      fsum_in = fsum_ff;
      csum_in = csum_ff;
      off_in = off_ff;
      filt_in = filt_ff;
      mv_in = mv_ff;
      res_cal_in = res_cal_ff;
      for (int i = 0; i < msc_pkg::NCH; i++) begin
         res_in[i] = res_ff[i];
         code_in[i] = code_ff[i];
      end
      rsp_valid_in = rsp_valid_ff;
      ram_we = 1'b0;
      ram_waddr = ch_ff;
      ram_raddr = ch_ff;
      ram_wdata = {fsum_ff, csum_ff, off_ff};
      div_start = 1'b0;
      div_num = '0;
      div_den = n_ff;
      wide_a = '0;
      wide_b = '0;
      diff = '0;
      prod = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         msc_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wdata = '0;
            ch_in = ch_ff + 1'b1;
            if (ch_ff == msc_pkg::CH_W'(msc_pkg::NCH - 1)) begin
               state_in = msc_pkg::ST_IDLE;
               busy_in = 1'b0;
            end
         end
         msc_pkg::ST_IDLE: begin
            if (accept) begin
               code_in[0] = req_code_ch0;
               code_in[1] = req_code_ch1;
               code_in[2] = req_code_ch2;
               code_in[3] = req_code_ch3;
               code_in[4] = req_code_ch4;
               code_in[5] = req_code_ch5;
               code_in[6] = req_code_ch6;
               code_in[7] = req_code_ch7;
               w_in = (window_ff == 8'd0) ? 8'd1 :
                      (window_ff > 8'(msc_pkg::COUNT_LIMIT)) ?
                      8'(msc_pkg::COUNT_LIMIT) : window_ff;
               n_in = (startup_ff >= 8'(msc_pkg::COUNT_LIMIT)) ?
                      8'(msc_pkg::COUNT_LIMIT) : startup_ff + 1'b1;
               startup_in = n_in;
               calact_in = calact_ff || req_calibrate_request;
               calupd_in = calact_in && (calcnt_ff < 8'(msc_pkg::CALIB_FRAMES));
               calfin_in = calact_in && !calupd_in;
               ch_in = '0;
               state_in = msc_pkg::ST_READ;
            end
         end
         msc_pkg::ST_READ: begin
            mv_in = 32'(code_ff[ch_ff] * $signed({1'b0, mv_gain_ff}));
            state_in = msc_pkg::ST_DIV1_START;
         end
         msc_pkg::ST_DIV1_START: begin
            fsum_in = $signed(ram_rdata[msc_pkg::RAM_W-1 -: msc_pkg::SUM_W]);
            csum_in = $signed(ram_rdata[msc_pkg::FILT_W +: msc_pkg::SUM_W]);
            off_in = $signed(ram_rdata[msc_pkg::FILT_W-1:0]);
            if (n_ff <= w_ff) begin
               wide_a = 64'(fsum_in) + 64'(mv_ff);
               wide_a = (wide_a > SUM_MAX) ? SUM_MAX : (wide_a < SUM_MIN) ? SUM_MIN : wide_a;
               fsum_in = msc_pkg::SUM_W'(wide_a);
               div_num = msc_pkg::DIV_W'(fsum_in);
               div_den = n_ff;
               div_start = 1'b1;
               state_in = msc_pkg::ST_DIV2_WAIT;
            end else begin
               div_num = msc_pkg::DIV_W'(fsum_in);
               div_den = w_ff;
               div_start = 1'b1;
               state_in = msc_pkg::ST_DIV1_WAIT;
            end
         end
         msc_pkg::ST_DIV1_WAIT: begin
            if (div_done) begin
               wide_a = 64'(fsum_ff) - 64'(div_q) + 64'(mv_ff);
               wide_a = (wide_a > SUM_MAX) ? SUM_MAX : (wide_a < SUM_MIN) ? SUM_MIN : wide_a;
               fsum_in = msc_pkg::SUM_W'(wide_a);
               state_in = msc_pkg::ST_DIV2_START;
            end
         end
         msc_pkg::ST_DIV2_START: begin
            div_num = msc_pkg::DIV_W'(fsum_ff);
            div_den = w_ff;
            div_start = 1'b1;
            state_in = msc_pkg::ST_DIV2_WAIT;
         end
         msc_pkg::ST_DIV2_WAIT: begin
            if (div_done) begin
               wide_a = 64'(div_q);
               wide_a = (wide_a > F_MAX) ? F_MAX : (wide_a < F_MIN) ? F_MIN : wide_a;
               filt_in = msc_pkg::FILT_W'(wide_a);
               if (calupd_ff) begin
                  wide_b = 64'(csum_ff) + wide_a;
                  wide_b = (wide_b > SUM_MAX) ? SUM_MAX : (wide_b < SUM_MIN) ? SUM_MIN : wide_b;
                  csum_in = msc_pkg::SUM_W'(wide_b);
                  state_in = msc_pkg::ST_WRITE;
               end else if (calfin_ff) begin
                  state_in = msc_pkg::ST_CAL_START;
               end else begin
                  state_in = msc_pkg::ST_WRITE;
               end
            end
         end
         msc_pkg::ST_CAL_START: begin
            div_num = msc_pkg::DIV_W'(csum_ff);
            div_den = (calcnt_ff == '0) ? 8'd1 : calcnt_ff;
            div_start = 1'b1;
            state_in = msc_pkg::ST_CAL_WAIT;
         end
         msc_pkg::ST_CAL_WAIT: begin
            if (div_done) begin
               wide_a = 64'(div_q);
               wide_a = (wide_a > F_MAX) ? F_MAX : (wide_a < F_MIN) ? F_MIN : wide_a;
               off_in = msc_pkg::FILT_W'(wide_a);
               csum_in = '0;
               state_in = msc_pkg::ST_WRITE;
            end
         end
         msc_pkg::ST_WRITE: begin
            ram_we = 1'b1;
            diff = 33'(filt_ff) - 33'(off_ff);
            prod = 51'(diff * $signed({1'b0, field_gain_ff})) + 51'sd32768;
            wide_a = 64'(prod >>> 16);
            wide_a = (wide_a > F_MAX) ? F_MAX : (wide_a < F_MIN) ? F_MIN : wide_a;
            res_in[ch_ff] = 32'(wide_a);
            ch_in = ch_ff + 1'b1;
            ram_raddr = ch_ff + 1'b1;
            if (ch_ff == msc_pkg::CH_W'(msc_pkg::NCH - 1)) begin
               if (calupd_ff) begin
                  calcnt_in = calcnt_ff + 1'b1;
               end else if (calfin_ff) begin
                  calcnt_in = '0;
                  calact_in = 1'b0;
               end
               res_cal_in = calact_in;
               state_in = msc_pkg::ST_OUT;
            end else begin
               state_in = msc_pkg::ST_READ;
            end
         end
         msc_pkg::ST_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in = msc_pkg::ST_IDLE;
            end
         end
         default: state_in = msc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msc_pkg::ST_CLEAR;
         busy_ff <= 1'b1;
         ch_ff <= '0;
         startup_ff <= '0;
         calcnt_ff <= '0;
         calact_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         ch_ff <= ch_in;
         startup_ff <= startup_in;
         calcnt_ff <= calcnt_in;
         calact_ff <= calact_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      w_ff <= w_in;
      calupd_ff <= calupd_in;
      calfin_ff <= calfin_in;
      fsum_ff <= fsum_in;
      csum_ff <= csum_in;
      off_ff <= off_in;
      filt_ff <= filt_in;
      mv_ff <= mv_in;
      res_cal_ff <= res_cal_in;
      for (int i = 0; i < msc_pkg::NCH; i++) begin
         res_ff[i] <= res_in[i];
         code_ff[i] <= code_in[i];
      end
      if (load_out) begin
         for (int i = 0; i < msc_pkg::NCH; i++) begin
            out_ff[i] <= res_ff[i];
         end
         out_cal_ff <= res_cal_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_field_ch0 = out_ff[0];
   assign rsp_field_ch1 = out_ff[1];
   assign rsp_field_ch2 = out_ff[2];
   assign rsp_field_ch3 = out_ff[3];
   assign rsp_field_ch4 = out_ff[4];
   assign rsp_field_ch5 = out_ff[5];
   assign rsp_field_ch6 = out_ff[6];
   assign rsp_field_ch7 = out_ff[7];
   assign rsp_calibrating = out_cal_ff;

endmodule

@@ tb/sv/multichannel_sample_conditioner_tb.sv @@
`timescale 1ns / 1ps

module multichannel_sample_conditioner_tb;

   localparam int IDLE_LIMIT = 20000;
   localparam logic signed [39:0] SUM_HI = 40'sh7FFFFFFFFF;
   localparam logic signed [39:0] SUM_LO = -40'sh8000000000;

   typedef struct {
      logic signed [31:0] field [msc_pkg::NCH];
      logic               calibrating;
   } frame_result_type;

   typedef struct {
      logic signed [15:0] code [msc_pkg::NCH];
      logic               cal;
      bit                 known;
      frame_result_type   res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_code [msc_pkg::NCH];
   logic req_calibrate_request = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_field [msc_pkg::NCH];
   logic rsp_calibrating;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic [7:0]  window_q;
   logic [15:0] mv_gain_q, field_gain_q;
   int unsigned warmup_n, cal_frames;
   logic signed [63:0] filt_acc [msc_pkg::NCH];
   logic signed [63:0] cal_acc [msc_pkg::NCH];
   logic signed [31:0] offset_q [msc_pkg::NCH];
   bit cal_running;

   frame_result_type expected_frames [$];
   stim_row_type rows [$];
   int fail_count = 0;
   int idle_cycles = 0;
   bit stalled_out = 0;
   int rsp_wait = 0;
   bit rsp_taken = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial for (int i = 0; i < msc_pkg::NCH; i++) req_code[i] = '0;

   multichannel_sample_conditioner DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_code_ch0(req_code[0]), .req_code_ch1(req_code[1]),
      .req_code_ch2(req_code[2]), .req_code_ch3(req_code[3]),
      .req_code_ch4(req_code[4]), .req_code_ch5(req_code[5]),
      .req_code_ch6(req_code[6]), .req_code_ch7(req_code[7]),
      .req_calibrate_request(req_calibrate_request),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_field_ch0(rsp_field[0]), .rsp_field_ch1(rsp_field[1]),
      .rsp_field_ch2(rsp_field[2]), .rsp_field_ch3(rsp_field[3]),
      .rsp_field_ch4(rsp_field[4]), .rsp_field_ch5(rsp_field[5]),
      .rsp_field_ch6(rsp_field[6]), .rsp_field_ch7(rsp_field[7]),
      .rsp_calibrating(rsp_calibrating),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   function automatic logic signed [63:0] clamp(logic signed [63:0] v,
                                                logic signed [63:0] lo,
                                                logic signed [63:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic signed [63:0] to_s32(logic signed [63:0] v);
      return clamp(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic int draw_wait();
      return stalled_out ? 7 : int'($urandom_range(0, 7));
   endfunction

   function automatic void reset_conditioner();
      window_q = 8'd5;
      mv_gain_q = 16'd9961;
      field_gain_q = 16'd10112;
      warmup_n = 0;
      cal_frames = 0;
      cal_running = 0;
      for (int i = 0; i < msc_pkg::NCH; i++) begin
         filt_acc[i] = 0;
         cal_acc[i] = 0;
         offset_q[i] = 0;
      end
   endfunction

   function automatic frame_result_type condition_frame(
      logic signed [15:0] code [msc_pkg::NCH], logic cal);
      frame_result_type r;
      logic signed [63:0] filt [msc_pkg::NCH];
      logic signed [63:0] mv, s, f, d, prod, q;
      int unsigned w, n;
      w = window_q;
      if (w == 0) w = 1;
      if (w > msc_pkg::COUNT_LIMIT) w = msc_pkg::COUNT_LIMIT;
      n = warmup_n + 1;
      if (n > msc_pkg::COUNT_LIMIT) n = msc_pkg::COUNT_LIMIT;
      warmup_n = n;
      for (int i = 0; i < msc_pkg::NCH; i++) begin
         mv = 64'(code[i]) * $signed({48'd0, mv_gain_q});
         s = filt_acc[i];
         if (n <= w) begin
            s = clamp(s + mv, SUM_LO, SUM_HI);
            f = s / $signed(64'(n));
         end else begin
            s = s - s / $signed(64'(w));
            s = clamp(s + mv, SUM_LO, SUM_HI);
            f = s / $signed(64'(w));
         end
         filt_acc[i] = s;
         filt[i] = to_s32(f);
      end
      if (cal) cal_running = 1;
      if (cal_running) begin
         if (cal_frames < msc_pkg::CALIB_FRAMES) begin
            for (int i = 0; i < msc_pkg::NCH; i++)
               cal_acc[i] = clamp(cal_acc[i] + filt[i], SUM_LO, SUM_HI);
            cal_frames++;
         end else begin
            d = (cal_frames != 0) ? 64'(cal_frames) : 64'sd1;
            for (int i = 0; i < msc_pkg::NCH; i++) begin
               offset_q[i] = 32'(to_s32(cal_acc[i] / d));
               cal_acc[i] = 0;
            end
            cal_frames = 0;
            cal_running = 0;
         end
      end
      for (int i = 0; i < msc_pkg::NCH; i++) begin
         d = filt[i] - 64'(offset_q[i]);
         prod = d * $signed({48'd0, field_gain_q}) + 64'sd32768;
         q = prod >>> 16;
         r.field[i] = 32'(to_s32(q));
      end
      r.calibrating = cal_running;
      return r;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         msc_pkg::REG_WINDOW: window_q = value[7:0];
         msc_pkg::REG_MV_GAIN: mv_gain_q = value[15:0];
         msc_pkg::REG_FIELD_GAIN: field_gain_q = value[15:0];
         default: ;
      endcase
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      stop_sending();
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_frame(input logic signed [15:0] code [msc_pkg::NCH], input logic cal,
                             input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < msc_pkg::NCH; i++) req_code[i] <= code[i];
      req_calibrate_request <= cal;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_frames.push_back(condition_frame(code, cal));
   endtask

   task automatic send_random(input int count, input int cal_odds);
      logic signed [15:0] c [msc_pkg::NCH];
      int mode;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < msc_pkg::NCH; i++)
            case (mode)
               0: c[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               1: c[i] = $signed(16'($urandom_range(0, 600))) - 16'sd300;
               default: c[i] = 16'($urandom);
            endcase
         send_frame(c, ($urandom_range(1, cal_odds) == 1),
                    stalled_out ? 0 : $urandom_range(0, 7));
      end
   endtask

   // response side: draw a wait per result, check on accept
   always @(negedge clock) begin
      int left;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         left = rsp_taken ? draw_wait() : rsp_wait;
         if (rsp_valid && left > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait <= left - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_wait <= left;
         end
      end
   end

   always @(posedge clock) begin
      frame_result_type e;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            $error("unexpected response");
            fail_count++;
         end else begin
            e = expected_frames.pop_front();
            for (int i = 0; i < msc_pkg::NCH; i++)
               if (rsp_field[i] !== e.field[i]) begin
                  $error("field_ch%0d: expected %0d, got %0d", i, e.field[i], rsp_field[i]);
                  fail_count++;
               end
            if (rsp_calibrating !== e.calibrating) begin
               $error("calibrating: expected %0d, got %0d", e.calibrating, rsp_calibrating);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else if (expected_frames.size() != 0 || req_valid)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      frame_result_type pred;
      reset_conditioner();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (20) @(negedge clock);

      // directed table: zero frame after reset yields zeros
      row.known = 1;
      for (int i = 0; i < msc_pkg::NCH; i++) begin
         row.code[i] = 0;
         row.res.field[i] = 0;
      end
      row.cal = 0;
      row.res.calibrating = 0;
      rows.push_back(row);
      row.known = 0;
      for (int i = 0; i < msc_pkg::NCH; i++) row.code[i] = 16'sh7FFF;
      rows.push_back(row);
      for (int i = 0; i < msc_pkg::NCH; i++) row.code[i] = 16'sh8000;
      rows.push_back(row);
      for (int i = 0; i < msc_pkg::NCH; i++) row.code[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
      rows.push_back(row);
      for (int i = 0; i < msc_pkg::NCH; i++) row.code[i] = $signed(16'(i * 1000)) - 16'sd3000;
      rows.push_back(row);
      row.cal = 1;
      rows.push_back(row);
      row.cal = 1;
      for (int i = 0; i < msc_pkg::NCH; i++) row.code[i] = 16'sh0001;
      rows.push_back(row);
      row.cal = 0;
      for (int i = 0; i < msc_pkg::NCH; i++) row.code[i] = -16'sd1;
      rows.push_back(row);

      foreach (rows[k]) begin
         send_frame(rows[k].code, rows[k].cal, rows[k].known ? 0 : $urandom_range(0, 7));
         if (rows[k].known) begin
            pred = expected_frames[$];
            for (int i = 0; i < msc_pkg::NCH; i++)
               if (pred.field[i] !== rows[k].res.field[i]) begin
                  $error("field_ch%0d: expected %0d, got %0d", i, rows[k].res.field[i],
                         pred.field[i]);
                  fail_count++;
               end
            if (pred.calibrating !== rows[k].res.calibrating) begin
               $error("calibrating: expected %0d, got %0d", rows[k].res.calibrating,
                      pred.calibrating);
               fail_count++;
            end
         end
      end

      // finish the calibration started above, then check the new offsets
      send_random(205, 1000);
      wait_drained();

      csr_write(msc_pkg::REG_WINDOW, 32'd1);
      csr_write(msc_pkg::REG_MV_GAIN, 32'd65535);
      csr_write(msc_pkg::REG_FIELD_GAIN, 32'd65535);
      send_random(150, 50);
      wait_drained();

      csr_write(msc_pkg::REG_WINDOW, 32'd0);
      csr_write(msc_pkg::REG_MV_GAIN, 32'd0);
      csr_write(msc_pkg::REG_FIELD_GAIN, 32'd0);
      send_random(20, 10);
      stalled_out = 1;
      send_random(20, 10);
      stalled_out = 0;
      wait_drained();

      csr_write(msc_pkg::REG_WINDOW, 32'd255);
      csr_write(msc_pkg::REG_MV_GAIN, 32'd40000);
      csr_write(msc_pkg::REG_FIELD_GAIN, 32'd30000);
      send_random(300, 60);
      wait_drained();

      csr_write(msc_pkg::REG_WINDOW, 32'd250);
      csr_write(msc_pkg::REG_MV_GAIN, 32'($urandom_range(0, 65535)));
      csr_write(msc_pkg::REG_FIELD_GAIN, 32'($urandom_range(0, 65535)));
      send_random(150, 80);
      wait_drained();

      csr_write(msc_pkg::REG_WINDOW, 32'($urandom_range(1, 250)));
      send_random(150, 40);
      stop_sending();

      fork
         begin
            wait (expected_frames.size() == 0);
            repeat (200) @(posedge clock);
         end
         begin
            repeat (20 * IDLE_LIMIT) @(posedge clock);
            fail_count++;
         end
      join_any
      if (fail_count == 0 && expected_frames.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
